// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CELL_W    = 16;
  // Cells moved by one scroll
  localparam int COPY_N    = COLUMNS * (ROWS - 1);

  // Command queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Character codes
  localparam logic [7:0] NEWLINE_CH = 8'h0A;
  localparam logic [7:0] SPACE_CH   = 8'h20;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_SETPOS = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG = 2'd0,
    CFG_BG = 2'd1
  } cfg_idx_e;

  // Command class decided by the front end
  typedef enum logic [2:0] {
    K_PUT     = 3'd0,
    K_NEWLINE = 3'd1,
    K_SETPOS  = 3'd2,
    K_READ    = 3'd3,
    K_NOP     = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] row;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_linear;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;
  } res_t;

  // Classified command as queued for the back end
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Linear cell address of a row and column
  function automatic logic [ADDR_W-1:0] lin_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS)) + ADDR_W'(c);
  endfunction

endpackage

// ===== rtl/core/tcw_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tcw_front.sv =====
`timescale 1ns / 1ps
// Front end: command acceptance, classification and color registers.
module tcw_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  tcw_pkg::cmd_t                   cmd_i,
  output logic                            busy_o,
  input  logic                            cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  tcw_pkg::q_stat_t                q_stat_i,
  input  logic                            clearing_i,
  output logic                            push_o,
  output tcw_pkg::entry_t                 entry_o,
  output logic [7:0]                      attr_o
);

  logic [3:0] fg_q, fg_d;
  logic [3:0] bg_q, bg_d;
  logic [tcw_pkg::COL_W-1:0] col_sat;
  logic [tcw_pkg::ROW_W-1:0] row_sat;

  // Color registers
  always_comb begin
    fg_d = fg_q;
    bg_d = bg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tcw_pkg::CFG_FG: fg_d = cfg_wdata_i;
        tcw_pkg::CFG_BG: bg_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= 4'd14;
      bg_q <= 4'd0;
    end else begin
      fg_q <= fg_d;
      bg_q <= bg_d;
    end
  end

  assign attr_o = {bg_q, fg_q};

  // Hold off while the queue is full or the screen is being cleared
  assign busy_o = q_stat_i.full | clearing_i;
  assign push_o = start_i & ~busy_o;

  // Clamp position to the screen
  always_comb begin
    if (32'(cmd_i.col) > 32'(tcw_pkg::COLUMNS - 1)) begin
      col_sat = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
    end else begin
      col_sat = tcw_pkg::COL_W'(cmd_i.col);
    end
    if (32'(cmd_i.row) > 32'(tcw_pkg::ROWS - 1)) begin
      row_sat = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
    end else begin
      row_sat = tcw_pkg::ROW_W'(cmd_i.row);
    end
  end

  // Classify
  always_comb begin
    entry_o.ch   = cmd_i.ch;
    entry_o.col  = col_sat;
    entry_o.row  = row_sat;
    entry_o.addr = tcw_pkg::lin_addr(row_sat, col_sat);
    case (cmd_i.op)
      tcw_pkg::OP_PUT: begin
        entry_o.kind = (cmd_i.ch == tcw_pkg::NEWLINE_CH) ? tcw_pkg::K_NEWLINE
                                                         : tcw_pkg::K_PUT;
      end
      tcw_pkg::OP_SETPOS: entry_o.kind = tcw_pkg::K_SETPOS;
      tcw_pkg::OP_READ:   entry_o.kind = tcw_pkg::K_READ;
      default:            entry_o.kind = tcw_pkg::K_NOP;
    endcase
  end

endmodule

// ===== rtl/core/tcw_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
module tcw_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tcw_pkg::entry_t   entry_i,
  input  logic              pop_i,
  output tcw_pkg::entry_t   entry_o,
  output tcw_pkg::q_stat_t  stat_o
);

  tcw_pkg::entry_t slot_q [tcw_pkg::QDEPTH];
  logic [tcw_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [tcw_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [tcw_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign stat_o.full  = (cnt_q == tcw_pkg::QCNT_W'(tcw_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i & ~stat_o.full;
  assign do_pop  = pop_i & ~stat_o.empty;
  assign entry_o = slot_q[rd_ptr_q];

  // Pointer wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == tcw_pkg::QPTR_W'(tcw_pkg::QDEPTH - 1)) ? '0
                                                                    : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == tcw_pkg::QPTR_W'(tcw_pkg::QDEPTH - 1)) ? '0
                                                                    : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/core/tcw_back.sv =====
`timescale 1ns / 1ps
// Back end: cursor, screen store sequencing, scroll and result register.
module tcw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcw_pkg::q_stat_t  q_stat_i,
  input  tcw_pkg::entry_t   entry_i,
  input  logic [7:0]        attr_i,
  output logic              pop_o,
  output logic              clearing_o,
  output logic              done_o,
  output tcw_pkg::res_t     res_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_EXEC  = 5'b00010,
    S_READ  = 5'b00100,
    S_COPY  = 5'b01000,
    S_BLANK = 5'b10000
  } state_e;

  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_ADDR = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] COPY_END  = tcw_pkg::ADDR_W'(tcw_pkg::COPY_N);
  localparam logic [tcw_pkg::COL_W-1:0]  LAST_COL  = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
  localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROW  = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

  state_e state_q, state_d;
  logic [tcw_pkg::ADDR_W-1:0] cnt_q, cnt_d;
  logic [tcw_pkg::ADDR_W-1:0] wa_q, wa_d;
  logic pend_q, pend_d;
  logic [tcw_pkg::COL_W-1:0] col_q, col_d;
  logic [tcw_pkg::ROW_W-1:0] row_q, row_d;
  logic done_q, done_d;
  tcw_pkg::res_t res_q, res_d;

  logic we, re;
  logic [tcw_pkg::ADDR_W-1:0] waddr, raddr;
  logic [tcw_pkg::CELL_W-1:0] wdata, rdata;
  logic [tcw_pkg::ADDR_W-1:0] lin_d;

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(tcw_pkg::CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign clearing_o = (state_q == S_CLEAR);

  // Sequencer
  always_comb begin
    logic nl;
    logic [7:0] rd_char, rd_attr;
    logic scr;
    nl       = 1'b0;
    rd_char  = '0;
    rd_attr  = '0;
    scr      = 1'b0;
    state_d  = state_q;
    cnt_d    = cnt_q;
    wa_d     = wa_q;
    pend_d   = 1'b0;
    col_d    = col_q;
    row_d    = row_q;
    done_d   = 1'b0;
    pop_o    = 1'b0;
    we       = 1'b0;
    waddr    = cnt_q;
    wdata    = '0;
    re       = 1'b0;
    raddr    = cnt_q;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = S_EXEC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_EXEC: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          case (entry_i.kind)
            tcw_pkg::K_PUT: begin
              we    = 1'b1;
              waddr = tcw_pkg::lin_addr(row_q, col_q);
              wdata = {attr_i, entry_i.ch};
              if (col_q == LAST_COL) begin
                nl = 1'b1;
              end else begin
                col_d  = col_q + 1'b1;
                done_d = 1'b1;
              end
            end
            tcw_pkg::K_NEWLINE: nl = 1'b1;
            tcw_pkg::K_SETPOS: begin
              col_d  = entry_i.col;
              row_d  = entry_i.row;
              done_d = 1'b1;
            end
            tcw_pkg::K_READ: begin
              re      = 1'b1;
              raddr   = entry_i.addr;
              state_d = S_READ;
            end
            default: done_d = 1'b1;
          endcase
          // Next line, or scroll from the bottom row
          if (nl) begin
            col_d = '0;
            if (row_q < LAST_ROW) begin
              row_d  = row_q + 1'b1;
              done_d = 1'b1;
            end else begin
              row_d   = LAST_ROW;
              cnt_d   = '0;
              state_d = S_COPY;
            end
          end
        end
      end
      S_READ: begin
        rd_char = rdata[7:0];
        rd_attr = rdata[15:8];
        done_d  = 1'b1;
        state_d = S_EXEC;
      end
      S_COPY: begin
        // Read one row down, write it back in the following cycle
        if (pend_q) begin
          we    = 1'b1;
          waddr = wa_q;
          wdata = rdata;
        end
        if (cnt_q != COPY_END) begin
          re     = 1'b1;
          raddr  = cnt_q + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
          pend_d = 1'b1;
          wa_d   = cnt_q;
          cnt_d  = cnt_q + 1'b1;
        end else begin
          state_d = S_BLANK;
        end
      end
      S_BLANK: begin
        we    = 1'b1;
        wdata = {attr_i, tcw_pkg::SPACE_CH};
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          scr     = 1'b1;
          done_d  = 1'b1;
          state_d = S_EXEC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = S_EXEC;
    endcase

    // Result assembly
    lin_d               = tcw_pkg::lin_addr(row_d, col_d);
    res_d               = res_q;
    if (done_d) begin
      res_d.cursor_col    = 7'(col_d);
      res_d.cursor_row    = 5'(row_d);
      res_d.cursor_linear = 11'(lin_d);
      res_d.cell_char     = rd_char;
      res_d.cell_attr     = rd_attr;
      res_d.scrolled      = scr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      col_q   <= col_d;
      row_q   <= row_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wa_q  <= wa_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/core/text_console_writer.sv =====
`timescale 1ns / 1ps
// Top level of the text console writer.
//
//  channel   signals                            transfer when
//  --------  ---------------------------------  ----------------------
//  command   start_i, busy_o, cmd_i             start_i && !busy_o
//  result    done_o, res_o                      done_o (one cycle)
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i   cfg_we_i
//
// Put and newline without scroll, set position and the unused op complete in
// S_EXEC; a read also passes through S_READ (registered store read). A scroll
// copies one cell per cycle on the single store write port, then blanks the
// bottom row. Results are registered, in the cycle after the work completes.
// After reset busy_o stays high while the store is cleared. A two-entry queue
// lets commands arrive while the back end works; results cannot be stalled.
module text_console_writer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  tcw_pkg::cmd_t                  cmd_i,
  output logic                           done_o,
  output tcw_pkg::res_t                  res_o,
  input  logic                           cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  tcw_pkg::q_stat_t q_stat;
  tcw_pkg::entry_t  push_entry;
  tcw_pkg::entry_t  head_entry;
  logic             push;
  logic             pop;
  logic             clearing;
  logic [7:0]       attr;

  tcw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cmd_i      (cmd_i),
    .busy_o     (busy_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_stat_i   (q_stat),
    .clearing_i (clearing),
    .push_o     (push),
    .entry_o    (push_entry),
    .attr_o     (attr)
  );

  tcw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .entry_o(head_entry),
    .stat_o (q_stat)
  );

  tcw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .entry_i   (head_entry),
    .attr_i    (attr),
    .pop_o     (pop),
    .clearing_o(clearing),
    .done_o    (done_o),
    .res_o     (res_o)
  );

endmodule

// ===== rtl/core/tcw_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the text console writer, bound to the top level.
module tcw_port_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          done_o,
  input tcw_pkg::res_t res_o
);

  // Cursor column stays on the screen
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(res_o.cursor_col) <= 32'(tcw_pkg::COLUMNS - 1)))
    else $error("cursor column off screen");

  // Linear cursor agrees with row and column
  a_linear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.cursor_linear ==
                11'(32'(res_o.cursor_row) * tcw_pkg::COLUMNS + 32'(res_o.cursor_col))))
    else $error("linear cursor mismatch");

  // A scroll leaves the cursor at the start of the bottom row
  a_scroll_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.scrolled) |->
      (res_o.cursor_col == 7'd0 && res_o.cursor_row == 5'(tcw_pkg::ROWS - 1)))
    else $error("cursor not at bottom row start after scroll");

  // A scroll passes through the copy and blank states, so two scrolled results cannot be adjacent
  a_scroll_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.scrolled) |=> !(done_o && res_o.scrolled))
    else $error("back-to-back scroll results");

endmodule

bind text_console_writer tcw_port_checker u_tcw_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .done_o(done_o),
  .res_o (res_o)
);
